[src/pcf_pkg.sv]
// Shared constants, opcodes, state codes and result bundle for the path corridor fixup block.
package pcf_pkg;

  localparam int PATH_DEPTH    = 256;
  localparam int VISITED_DEPTH = 16;

  localparam int PATH_AW = $clog2(PATH_DEPTH);
  localparam int CNT_W   = $clog2(PATH_DEPTH + 1);
  localparam int VIS_AW  = (VISITED_DEPTH > 1) ? $clog2(VISITED_DEPTH) : 1;
  localparam int VIS_CW  = $clog2(VISITED_DEPTH + 1);

  localparam int OPCODE_W = 3;
  localparam int REF_W    = 64;
  localparam int INDEX_W  = 8;
  localparam int PLEN_W   = 9;
  localparam int VLEN_W   = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR        = 3'd0,
    OP_APPEND_PATH  = 3'd1,
    OP_APPEND_VISIT = 3'd2,
    OP_FIXUP        = 3'd3,
    OP_READ         = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_SETUP,
    ST_COPY,
    ST_VIS
  } state_t;

  typedef struct packed {
    logic [REF_W-1:0]  read_value;
    logic [PLEN_W-1:0] path_length;
    logic [VLEN_W-1:0] visited_length;
    logic              matched;
    logic              rejected;
  } res_t;

endpackage

[src/pcf_cmd_if.sv]
// Command channel interface: one operation per transaction.
interface pcf_cmd_if import pcf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [REF_W-1:0]    poly_ref;
  logic [INDEX_W-1:0]  read_index;

  modport source (output valid, output opcode, output poly_ref, output read_index,
                  input ready);
  modport sink   (input valid, input opcode, input poly_ref, input read_index,
                  output ready);
endinterface

[src/pcf_res_if.sv]
// Result channel interface: one result per transaction.
interface pcf_res_if import pcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REF_W-1:0]  read_value;
  logic [PLEN_W-1:0] path_length;
  logic [VLEN_W-1:0] visited_length;
  logic              matched;
  logic              rejected;

  modport source (output valid, output read_value, output path_length,
                  output visited_length, output matched, output rejected,
                  input ready);
  modport sink   (input valid, input read_value, input path_length,
                  input visited_length, input matched, input rejected,
                  output ready);
endinterface

[src/path_corridor_fixup_top.sv]
// Path corridor fixup block: corridor memory, visited list and fixup sequencer.
//
// The corridor lives in a single-port-read, single-port-write synchronous RAM and the
// visited list in a small register file. Every command transaction returns exactly one
// result transaction. Clear, both appends and unused opcodes are answered from ST_IDLE; a
// read passes through ST_READ. A fixup is bounded by the corridor RAM port: it starts in
// ST_IDLE, scans corridor entries from the end down to the match (all visited entries
// are compared in parallel), passes one setup state, slides the kept tail (no copy when
// the tail is empty or stays in place), and writes the visited entries from the match
// on at the front. A fixup with an empty list returns without reading the corridor; one
// without a match scans the whole corridor.
// A new command is taken while one finished result waits at the output.
module path_corridor_fixup_top import pcf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  pcf_cmd_if.sink  cmd,
  pcf_res_if.source res
);

  // Corridor RAM.
  logic [REF_W-1:0] mem [PATH_DEPTH];
  logic [REF_W-1:0] rdata;
  logic               mem_we;
  logic [PATH_AW-1:0] mem_waddr;
  logic [REF_W-1:0]   mem_wdata;
  logic               mem_re;
  logic [PATH_AW-1:0] mem_raddr;

  // Visited register file.
  logic [REF_W-1:0] vis [VISITED_DEPTH];
  logic              vis_we;
  logic [VIS_AW-1:0] vis_waddr;

  state_t state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [VIS_CW-1:0]  vcnt, vcnt_next;
  logic [PATH_AW-1:0] chk_addr, chk_addr_next;
  logic [PATH_AW-1:0] hit_path, hit_path_next;
  logic [VIS_AW-1:0]  hit_vis, hit_vis_next;
  logic [VIS_CW-1:0]  req, req_next;
  logic [CNT_W-1:0]   new_cnt, new_cnt_next;
  logic [PATH_AW-1:0] cp_src, cp_src_next;
  logic [PATH_AW-1:0] cp_dst, cp_dst_next;
  logic [CNT_W-1:0]   cp_left, cp_left_next;
  logic               cp_down, cp_down_next;
  logic               cp_pend, cp_pend_next;
  logic [PATH_AW-1:0] cp_pdst, cp_pdst_next;
  logic [VIS_CW-1:0]  vk, vk_next;
  logic               rd_ok, rd_ok_next;

  logic              in_ready;
  logic              accept;
  logic              res_fire;
  res_t              res_data;
  logic [REF_W-1:0]  res_value;
  logic              res_matched;
  logic              res_rejected;

  // Parallel compare of the returned corridor entry against the live visited entries.
  logic [VISITED_DEPTH-1:0] eq;
  logic                     any_hit;
  logic [VIS_AW-1:0]        lo_hit;

  // Setup arithmetic.
  logic [CNT_W-1:0] orig;
  logic [CNT_W-1:0] size0;
  logic [CNT_W:0]   span;
  logic [CNT_W-1:0] size;
  logic [CNT_W-1:0] req_ext;
  logic [VIS_AW-1:0] vis_ridx;

  // Output register and one-deep hold stage.
  res_t out_q, hold_q;
  logic out_valid, hold_valid;
  logic slot_free;

  assign in_ready  = (state == ST_IDLE) && !hold_valid;
  assign cmd.ready = in_ready;
  assign accept    = cmd.valid && in_ready;

  always_comb begin
    any_hit = 1'b0;
    lo_hit  = '0;
    for (int j = VISITED_DEPTH - 1; j >= 0; j--) begin
      eq[j] = (VIS_CW'(j) < vcnt) && (rdata == vis[j]);
      if (eq[j]) begin
        any_hit = 1'b1;
        lo_hit  = VIS_AW'(j);
      end
    end
  end

  always_comb begin
    req_ext = CNT_W'(req);
    orig    = CNT_W'(hit_path) + CNT_W'(1);
    size0   = cnt - orig;
    span    = (CNT_W + 1)'(req_ext) + (CNT_W + 1)'(size0);
    if (span > (CNT_W + 1)'(PATH_DEPTH)) begin
      size = CNT_W'(PATH_DEPTH) - req_ext;
    end else begin
      size = size0;
    end
  end

  assign vis_ridx = VIS_AW'(vcnt - VIS_CW'(1) - vk);

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    vcnt_next     = vcnt;
    chk_addr_next = chk_addr;
    hit_path_next = hit_path;
    hit_vis_next  = hit_vis;
    req_next      = req;
    new_cnt_next  = new_cnt;
    cp_src_next   = cp_src;
    cp_dst_next   = cp_dst;
    cp_left_next  = cp_left;
    cp_down_next  = cp_down;
    cp_pend_next  = cp_pend;
    cp_pdst_next  = cp_pdst;
    vk_next       = vk;
    rd_ok_next    = rd_ok;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = cmd.poly_ref;
    mem_re    = 1'b0;
    mem_raddr = '0;
    vis_we    = 1'b0;
    vis_waddr = vcnt[VIS_AW-1:0];

    res_fire     = 1'b0;
    res_value    = '0;
    res_matched  = 1'b0;
    res_rejected = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd.opcode)
            OP_CLEAR: begin
              cnt_next  = '0;
              vcnt_next = '0;
              res_fire  = 1'b1;
            end
            OP_APPEND_PATH: begin
              res_fire = 1'b1;
              if (cnt < CNT_W'(PATH_DEPTH)) begin
                mem_we    = 1'b1;
                mem_waddr = cnt[PATH_AW-1:0];
                cnt_next  = cnt + CNT_W'(1);
              end else begin
                res_rejected = 1'b1;
              end
            end
            OP_APPEND_VISIT: begin
              res_fire = 1'b1;
              if (vcnt < VIS_CW'(VISITED_DEPTH)) begin
                vis_we    = 1'b1;
                vcnt_next = vcnt + VIS_CW'(1);
              end else begin
                res_rejected = 1'b1;
              end
            end
            OP_FIXUP: begin
              if (cnt == '0 || vcnt == '0) begin
                vcnt_next = '0;
                res_fire  = 1'b1;
              end else begin
                mem_re        = 1'b1;
                mem_raddr     = PATH_AW'(cnt - CNT_W'(1));
                chk_addr_next = PATH_AW'(cnt - CNT_W'(1));
                state_next    = ST_SCAN;
              end
            end
            OP_READ: begin
              mem_re     = 1'b1;
              mem_raddr  = PATH_AW'(cmd.read_index);
              rd_ok_next = CNT_W'(cmd.read_index) < cnt;
              state_next = ST_READ;
            end
            default: begin
              res_fire = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        res_fire     = 1'b1;
        res_value    = rd_ok ? rdata : '0;
        res_rejected = !rd_ok;
        state_next   = ST_IDLE;
      end

      ST_SCAN: begin
        if (any_hit) begin
          hit_path_next = chk_addr;
          hit_vis_next  = lo_hit;
          req_next      = vcnt - VIS_CW'(lo_hit);
          state_next    = ST_SETUP;
        end else if (chk_addr == '0) begin
          vcnt_next  = '0;
          res_fire   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          mem_re        = 1'b1;
          mem_raddr     = chk_addr - PATH_AW'(1);
          chk_addr_next = chk_addr - PATH_AW'(1);
        end
      end

      ST_SETUP: begin
        new_cnt_next = req_ext + size;
        cp_down_next = req_ext > orig;
        // A tail that does not move needs no copy.
        cp_left_next = (req_ext == orig) ? '0 : size;
        if (req_ext > orig) begin
          // Sliding toward higher addresses runs from the end so no source is overwritten.
          cp_src_next = PATH_AW'(orig + size - CNT_W'(1));
          cp_dst_next = PATH_AW'(req_ext + size - CNT_W'(1));
        end else begin
          cp_src_next = PATH_AW'(orig);
          cp_dst_next = PATH_AW'(req_ext);
        end
        cp_pend_next = 1'b0;
        state_next   = ST_COPY;
      end

      ST_COPY: begin
        if (cp_pend) begin
          mem_we    = 1'b1;
          mem_waddr = cp_pdst;
          mem_wdata = rdata;
        end
        if (cp_left != '0) begin
          mem_re       = 1'b1;
          mem_raddr    = cp_src;
          cp_pend_next = 1'b1;
          cp_pdst_next = cp_dst;
          cp_left_next = cp_left - CNT_W'(1);
          if (cp_down) begin
            cp_src_next = cp_src - PATH_AW'(1);
            cp_dst_next = cp_dst - PATH_AW'(1);
          end else begin
            cp_src_next = cp_src + PATH_AW'(1);
            cp_dst_next = cp_dst + PATH_AW'(1);
          end
        end else begin
          cp_pend_next = 1'b0;
          if (!cp_pend) begin
            vk_next    = '0;
            state_next = ST_VIS;
          end
        end
      end

      ST_VIS: begin
        mem_we    = 1'b1;
        mem_waddr = PATH_AW'(vk);
        mem_wdata = vis[vis_ridx];
        if (vk == req - VIS_CW'(1)) begin
          cnt_next    = new_cnt;
          vcnt_next   = '0;
          res_fire    = 1'b1;
          res_matched = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          vk_next = vk + VIS_CW'(1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res_data.read_value     = res_value;
    res_data.path_length    = PLEN_W'(cnt_next);
    res_data.visited_length = VLEN_W'(vcnt_next);
    res_data.matched        = res_matched;
    res_data.rejected       = res_rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      vcnt    <= '0;
      cp_pend <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      vcnt    <= vcnt_next;
      cp_pend <= cp_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr <= chk_addr_next;
    hit_path <= hit_path_next;
    hit_vis  <= hit_vis_next;
    req      <= req_next;
    new_cnt  <= new_cnt_next;
    cp_src   <= cp_src_next;
    cp_dst   <= cp_dst_next;
    cp_left  <= cp_left_next;
    cp_down  <= cp_down_next;
    cp_pdst  <= cp_pdst_next;
    vk       <= vk_next;
    rd_ok    <= rd_ok_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis[vis_waddr] <= cmd.poly_ref;
    end
  end

  // No command is taken while the hold stage is full, so it never competes with a new result.
  assign slot_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (slot_free) begin
        out_valid  <= hold_valid || res_fire;
        hold_valid <= 1'b0;
      end else if (res_fire) begin
        hold_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (hold_valid) begin
        out_q <= hold_q;
      end else if (res_fire) begin
        out_q <= res_data;
      end
    end else if (res_fire) begin
      hold_q <= res_data;
    end
  end

  assign res.valid          = out_valid;
  assign res.read_value     = out_q.read_value;
  assign res.path_length    = out_q.path_length;
  assign res.visited_length = out_q.visited_length;
  assign res.matched        = out_q.matched;
  assign res.rejected       = out_q.rejected;

endmodule
